// ===== hw/rtl/rfs_pkg.sv =====
package rfs_pkg;

   typedef struct packed {
      logic [15:0] sample;
      logic        last_in_frame;
   } rfs_req_type;

   typedef struct packed {
      logic [63:0] metric_value;
      logic [24:0] pixel_count;
      logic [15:0] min_sample;
      logic [15:0] max_sample;
      logic        empty_region;
      logic        zero_mean;
   } rfs_rsp_type;

   // register indexes
   localparam logic [2:0] REG_ROI_X      = 3'd0;
   localparam logic [2:0] REG_ROI_Y      = 3'd1;
   localparam logic [2:0] REG_ROI_WIDTH  = 3'd2;
   localparam logic [2:0] REG_ROI_HEIGHT = 3'd3;
   localparam logic [2:0] REG_LINE_WIDTH = 3'd4;
   localparam logic [2:0] REG_METRIC     = 3'd5;

   // metric codes
   localparam logic [1:0] METRIC_SUM  = 2'd0;
   localparam logic [1:0] METRIC_MEAN = 2'd1;
   localparam logic [1:0] METRIC_STD  = 2'd2;
   localparam logic [1:0] METRIC_CV   = 2'd3;

   localparam int unsigned COUNT_CAP = 32'd16777216;

   // controller to datapath commands
   typedef struct packed {
      logic accumulate;   // accept a sample
      logic snapshot;     // latch frame totals, clear accumulators
      logic mul_start;    // start variance products
      logic sqrt_start;   // start root
      logic div_start;    // start divide
      logic div_by_sum;   // divisor is sum instead of count
      logic div_mean;     // dividend is sum << 16
      logic load_result;  // write output register
   } rfs_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic sqrt_done;
      logic div_done;
      logic frame_empty;  // latched frame has no sample in the region
      logic frame_zmean;  // latched frame has a zero sum
   } rfs_sts_type;

endpackage

// ===== hw/rtl/rfs_datapath.sv =====
module rfs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rfs_pkg::rfs_cmd_type cmd,
   output rfs_pkg::rfs_sts_type sts,
   input  rfs_pkg::rfs_req_type req_data,
   input  logic [11:0]         cfg_x,
   input  logic [11:0]         cfg_y,
   input  logic [12:0]         cfg_w,
   input  logic [12:0]         cfg_h,
   input  logic [12:0]         cfg_lw,
   input  logic [1:0]          cfg_metric,
   output rfs_pkg::rfs_rsp_type result
);
   import rfs_pkg::*;

   // accumulation state
   logic [11:0] col_ff, row_ff;
   logic [39:0] sum_ff;
   logic [55:0] sq_ff;
   logic [15:0] min_ff, max_ff;
   logic [24:0] cnt_ff;

   // frame snapshot
   logic [39:0] fsum_ff;
   logic [55:0] fsq_ff;
   logic [15:0] fmin_ff, fmax_ff;
   logic [24:0] fcnt_ff;

   logic [12:0] lw_eff;
   logic        in_roi;
   logic [12:0] col_rel, row_rel;
   logic [31:0] sq_smp;

   always_comb begin
      lw_eff  = (cfg_lw == 13'd0 || cfg_lw > 13'd4096) ? 13'd4096 : cfg_lw;
      col_rel = {1'b0, col_ff} - {1'b0, cfg_x};
      row_rel = {1'b0, row_ff} - {1'b0, cfg_y};
      in_roi  = (col_ff >= cfg_x) && (col_rel < cfg_w) &&
                (row_ff >= cfg_y) && (row_rel < cfg_h);
      sq_smp  = req_data.sample * req_data.sample;
   end

   // accumulators and position counters
   always_ff @(posedge clock) begin
      if (reset || cmd.snapshot) begin
         col_ff <= '0;
         row_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         min_ff <= '1;
         max_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.accumulate) begin
         if (in_roi && cnt_ff < 25'(COUNT_CAP)) begin
            cnt_ff <= cnt_ff + 25'd1;
            sum_ff <= sum_ff + 40'(req_data.sample);
            sq_ff  <= sq_ff + 56'(sq_smp);
            if (req_data.sample < min_ff) min_ff <= req_data.sample;
            if (req_data.sample > max_ff) max_ff <= req_data.sample;
         end
         if ({1'b0, col_ff} + 13'd1 >= lw_eff) begin
            col_ff <= '0;
            row_ff <= row_ff + 12'd1;
         end else begin
            col_ff <= col_ff + 12'd1;
         end
      end
   end

   // snapshot of the totals including the last transaction
   logic [24:0] cnt_nx;
   logic [39:0] sum_nx;
   logic [55:0] sq_nx;
   logic [15:0] min_nx, max_nx;
   always_comb begin
      cnt_nx = cnt_ff; sum_nx = sum_ff; sq_nx = sq_ff; min_nx = min_ff; max_nx = max_ff;
      if (in_roi && cnt_ff < 25'(COUNT_CAP)) begin
         cnt_nx = cnt_ff + 25'd1;
         sum_nx = sum_ff + 40'(req_data.sample);
         sq_nx  = sq_ff + 56'(sq_smp);
         if (req_data.sample < min_ff) min_nx = req_data.sample;
         if (req_data.sample > max_ff) max_nx = req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snapshot) begin
         fcnt_ff <= cnt_nx;
         fsum_ff <= sum_nx;
         fsq_ff  <= sq_nx;
         fmin_ff <= min_nx;
         fmax_ff <= max_nx;
      end
   end

   // variance numerator n*S2 - S^2 by 32x32 partial products, one per cycle
   // operands: a is n (25b) or S (40b) split in 2 halves; b is S2 (56b) or S
   logic [2:0]   mstep_ff;
   logic         mbusy_ff;
   logic [111:0] acc_ff;
   logic [31:0]  ma, mb;
   logic [63:0]  mprod;
   logic [6:0]   mshift;
   logic         msub;
   always_comb begin
      ma = '0; mb = '0; mshift = '0; msub = 1'b0;
      unique case (mstep_ff)
         3'd0: begin ma = 32'(fcnt_ff); mb = fsq_ff[31:0]; end
         3'd1: begin ma = 32'(fcnt_ff); mb = 32'(fsq_ff[55:32]); mshift = 7'd32; end
         3'd2: begin ma = fsum_ff[31:0]; mb = fsum_ff[31:0]; msub = 1'b1; end
         3'd3: begin ma = fsum_ff[31:0]; mb = 32'(fsum_ff[39:32]); mshift = 7'd33;
                     msub = 1'b1; end
         default: begin ma = 32'(fsum_ff[39:32]); mb = 32'(fsum_ff[39:32]);
                     mshift = 7'd64; msub = 1'b1; end
      endcase
      mprod = ma * mb;
   end

   // done follows the cycle in which the last product lands in the sum
   logic [63:0]  mprod_ff;
   logic [6:0]   mshift_ff;
   logic         msub_ff, mvalid_ff, mdone_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mvalid_ff <= 1'b0;
         mdone_ff <= 1'b0;
         mstep_ff <= '0;
      end else begin
         mvalid_ff <= mbusy_ff;
         mdone_ff <= mvalid_ff && !mbusy_ff;
         if (cmd.mul_start) begin
            mbusy_ff <= 1'b1;
            mstep_ff <= '0;
         end else if (mbusy_ff) begin
            if (mstep_ff == 3'd4) mbusy_ff <= 1'b0;
            mstep_ff <= mstep_ff + 3'd1;
         end
      end
   end
   always_ff @(posedge clock) begin
      mprod_ff  <= mprod;
      mshift_ff <= mshift;
      msub_ff   <= msub;
      if (cmd.mul_start) acc_ff <= '0;
      else if (mvalid_ff) begin
         if (msub_ff) acc_ff <= acc_ff - (112'(mprod_ff) << mshift_ff);
         else         acc_ff <= acc_ff + (112'(mprod_ff) << mshift_ff);
      end
   end
   assign sts.mul_done = mdone_ff;

   // restoring square root of d << 32, one result bit per cycle
   // d stays below 2^80, so d << 32 fits in 112 bits
   logic [111:0] rad_ff;
   logic [57:0]  rem_ff;
   logic [55:0]  root_ff;
   logic [5:0]   sidx_ff;
   logic         sbusy_ff, sdone_ff;
   logic [57:0]  trial, rem_sh;
   always_comb begin
      rem_sh = {rem_ff[55:0], rad_ff[111:110]};
      trial  = {root_ff, 2'b01};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
         sdone_ff <= 1'b0;
      end else begin
         sdone_ff <= 1'b0;
         if (cmd.sqrt_start) begin
            sbusy_ff <= 1'b1;
            sidx_ff  <= 6'd55;
            rad_ff   <= {acc_ff[79:0], 32'd0};
            rem_ff   <= '0;
            root_ff  <= '0;
         end else if (sbusy_ff) begin
            rad_ff <= rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[54:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[54:0], 1'b0};
            end
            if (sidx_ff == 6'd0) begin
               sbusy_ff <= 1'b0;
               sdone_ff <= 1'b1;
            end
            sidx_ff <= sidx_ff - 6'd1;
         end
      end
   end
   assign sts.sqrt_done = sdone_ff;

   // restoring divider, 64-bit dividend, one quotient bit per cycle
   logic [63:0] quo_ff;
   logic [40:0] drem_ff;
   logic [39:0] dvs_ff;
   logic [6:0]  didx_ff;
   logic        dbusy_ff, ddone_ff;
   logic [40:0] drem_sh;
   always_comb drem_sh = {drem_ff[39:0], quo_ff[63]};
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
            didx_ff  <= 7'd63;
            drem_ff  <= '0;
            quo_ff   <= cmd.div_mean ? {8'd0, fsum_ff, 16'd0} : {8'd0, root_ff};
            dvs_ff   <= cmd.div_by_sum ? fsum_ff : 40'(fcnt_ff);
         end else if (dbusy_ff) begin
            if (drem_sh >= {1'b0, dvs_ff}) begin
               drem_ff <= drem_sh - {1'b0, dvs_ff};
               quo_ff  <= {quo_ff[62:0], 1'b1};
            end else begin
               drem_ff <= drem_sh;
               quo_ff  <= {quo_ff[62:0], 1'b0};
            end
            if (didx_ff == 7'd0) begin
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end
            didx_ff <= didx_ff - 7'd1;
         end
      end
   end
   assign sts.div_done = ddone_ff;

   // result register
   logic empty, zmean;
   always_comb begin
      empty = (fcnt_ff == '0);
      zmean = !empty && (fsum_ff == '0);
   end
   assign sts.frame_empty = empty;
   assign sts.frame_zmean = zmean;

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         result.pixel_count  <= fcnt_ff;
         result.min_sample   <= empty ? 16'd0 : fmin_ff;
         result.max_sample   <= empty ? 16'd0 : fmax_ff;
         result.empty_region <= empty;
         result.zero_mean    <= zmean;
         if (empty || (cfg_metric == METRIC_CV && zmean))
            result.metric_value <= '0;
         else if (cfg_metric == METRIC_SUM)
            result.metric_value <= {8'd0, fsum_ff, 16'd0};
         else
            result.metric_value <= quo_ff;
      end
   end
endmodule

// ===== hw/rtl/rfs_ctrl.sv =====
module rfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           cfg_metric,
   output rfs_pkg::rfs_cmd_type cmd,
   input  rfs_pkg::rfs_sts_type sts
);
   import rfs_pkg::*;

   typedef enum logic [2:0] {
      ST_ACC, ST_DECIDE, ST_MUL, ST_SQRT, ST_DIV, ST_LOAD, ST_OUT
   } state_type;

   state_type state_ff;
   logic      acc_go;

   always_comb begin
      req_ready  = (state_ff == ST_ACC);
      rsp_valid  = (state_ff == ST_OUT);
      acc_go     = req_valid && req_ready;
      cmd            = '0;
      cmd.accumulate = acc_go;
      cmd.snapshot   = acc_go && req_last;
      cmd.div_by_sum = (cfg_metric == METRIC_CV);
      cmd.div_mean   = (cfg_metric == METRIC_MEAN);
      cmd.load_result = (state_ff == ST_LOAD);
      if (state_ff == ST_DECIDE) begin
         if (!(sts.frame_empty || cfg_metric == METRIC_SUM ||
               (cfg_metric == METRIC_CV && sts.frame_zmean))) begin
            cmd.mul_start = (cfg_metric != METRIC_MEAN);
            cmd.div_start = (cfg_metric == METRIC_MEAN);
         end
      end
      if (state_ff == ST_MUL && sts.mul_done) cmd.sqrt_start = 1'b1;
      if (state_ff == ST_SQRT && sts.sqrt_done) cmd.div_start = 1'b1;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
      end else begin
         unique case (state_ff)
            ST_ACC:    if (acc_go && req_last) state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (sts.frame_empty || cfg_metric == METRIC_SUM ||
                   (cfg_metric == METRIC_CV && sts.frame_zmean))
                  state_ff <= ST_LOAD;
               else if (cfg_metric == METRIC_MEAN) state_ff <= ST_DIV;
               else state_ff <= ST_MUL;
            end
            ST_MUL:  if (sts.mul_done) state_ff <= ST_SQRT;
            ST_SQRT: if (sts.sqrt_done) state_ff <= ST_DIV;
            ST_DIV:  if (sts.div_done) state_ff <= ST_LOAD;
            ST_LOAD: state_ff <= ST_OUT;
            ST_OUT:  if (rsp_ready) state_ff <= ST_ACC;
            default: state_ff <= ST_ACC;
         endcase
      end
   end
endmodule

// ===== hw/rtl/roi_frame_statistics_core.sv =====
// Region-of-interest statistics over a raster-ordered frame.
// Input channel req_*: one sample per transaction, req_data.last_in_frame
// marks the end of a frame. Samples are taken one per cycle during a frame.
// Result channel rsp_*: one transaction per frame, issued after the last
// sample. rsp_valid rises once the result register is loaded: directly
// for sum, an empty region or a zero-mean coefficient of variation; after
// the 64-step divider for mean; after 5 partial products, a 56-step square
// root, then the 64-step divider for standard deviation or coefficient of
// variation. During that time and until the result is taken, req_ready is
// low. A stalled result simply holds.
// Configuration channel csr_*: index and data, always ready; write only while
// no frame is in progress. Reset (synchronous) restores register defaults,
// clears counters and accumulators; no clearing pass is needed.
module roi_frame_statistics_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rfs_pkg::rfs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rfs_pkg::rfs_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [12:0]          csr_data
);
   import rfs_pkg::*;

   logic [11:0] x_ff, y_ff;
   logic [12:0] w_ff, h_ff, lw_ff;
   logic [1:0]  metric_ff;
   rfs_cmd_type cmd;
   rfs_sts_type sts;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0; y_ff <= '0;
         w_ff <= 13'd1024; h_ff <= 13'd1024; lw_ff <= 13'd1024;
         metric_ff <= METRIC_SUM;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROI_X:      x_ff <= csr_data[11:0];
            REG_ROI_Y:      y_ff <= csr_data[11:0];
            REG_ROI_WIDTH:  w_ff <= csr_data;
            REG_ROI_HEIGHT: h_ff <= csr_data;
            REG_LINE_WIDTH: lw_ff <= csr_data;
            REG_METRIC:     metric_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   rfs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_last(req_data.last_in_frame),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cfg_metric(metric_ff),
      .cmd(cmd), .sts(sts)
   );

   rfs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_data(req_data),
      .cfg_x(x_ff), .cfg_y(y_ff), .cfg_w(w_ff), .cfg_h(h_ff),
      .cfg_lw(lw_ff), .cfg_metric(metric_ff),
      .result(rsp_data)
   );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import rfs_pkg::*;

   // one queued input transaction, optionally with a hand-written result
   typedef struct {
      rfs_req_type req;
      bit          typed;
      rfs_rsp_type res;
   } sample_item_type;

   // one directed frame: settings, up to four samples, optional known result
   typedef struct {
      logic [12:0] lw, x, y, w, h;
      logic [1:0]  metric;
      int          cnt;
      logic [63:0] samples;
      bit          typed;
      rfs_rsp_type res;
   } frame_row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int HOLD_CYCLES    = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rfs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rfs_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   roi_frame_statistics_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sample_item_type sample_queue[$];
   sample_item_type in_flight;
   rfs_rsp_type     pending_stats[$];
   bit              failed = 1'b0;
   int              frames_done = 0;
   int              items_sent = 0;
   bit              req_taken = 1'b0;

   // predictor copy of registers and accumulators
   logic [11:0] cfg_x, cfg_y;
   logic [12:0] cfg_w, cfg_h, cfg_lw;
   logic [1:0]  cfg_metric;
   int unsigned col_pos, row_pos, n_inside;
   logic [39:0] acc_sum;
   logic [55:0] acc_sq;
   logic [15:0] acc_min, acc_max;

   task automatic clear_accumulators();
      col_pos = 0; row_pos = 0; n_inside = 0;
      acc_sum = '0; acc_sq = '0; acc_min = 16'hFFFF; acc_max = '0;
   endtask

   // floor square root of a value below 2^112
   function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 55; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= v) r = t;
      end
      return r;
   endfunction

   // accumulate one accepted sample, return the frame result on the last one
   task automatic frame_stats_step(input rfs_req_type rq, output bit done,
                                   output rfs_rsp_type res);
      int unsigned  lw;
      bit           in_roi;
      logic [127:0] d;
      logic [63:0]  root;
      lw = cfg_lw;
      if (lw == 0 || lw > 4096) lw = 4096;
      in_roi = col_pos >= cfg_x && col_pos - cfg_x < cfg_w &&
               row_pos >= cfg_y && row_pos - cfg_y < cfg_h;
      if (in_roi && n_inside < COUNT_CAP) begin
         n_inside++;
         acc_sum += rq.sample;
         acc_sq += 56'(rq.sample) * 56'(rq.sample);
         if (rq.sample < acc_min) acc_min = rq.sample;
         if (rq.sample > acc_max) acc_max = rq.sample;
      end
      if (col_pos + 1 >= lw) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= 4096) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      done = rq.last_in_frame;
      res = '0;
      if (!done) return;
      res.pixel_count = 25'(n_inside);
      res.empty_region = (n_inside == 0);
      res.zero_mean = (n_inside != 0) && (acc_sum == 0);
      if (n_inside != 0) begin
         res.min_sample = acc_min;
         res.max_sample = acc_max;
         d = 128'(n_inside) * 128'(acc_sq) - 128'(acc_sum) * 128'(acc_sum);
         case (cfg_metric)
            METRIC_SUM: res.metric_value = 64'(acc_sum) << 16;
            METRIC_MEAN: res.metric_value = (64'(acc_sum) << 16) / n_inside;
            METRIC_STD: begin
               root = isqrt(d << 32);
               res.metric_value = root / n_inside;
            end
            default: begin
               if (!res.zero_mean) begin
                  root = isqrt(d << 32);
                  res.metric_value = root / 64'(acc_sum);
               end
            end
         endcase
      end
      clear_accumulators();
   endtask

   // monitor: predictor on input transactions, checks on result transactions
   always @(posedge clock) begin
      bit          done;
      rfs_rsp_type got_exp;
      rfs_rsp_type calc;
      if (reset) begin
         cfg_x = 0; cfg_y = 0; cfg_w = 1024; cfg_h = 1024; cfg_lw = 1024;
         cfg_metric = METRIC_SUM;
         clear_accumulators();
         req_taken <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROI_X: cfg_x = csr_data[11:0];
               REG_ROI_Y: cfg_y = csr_data[11:0];
               REG_ROI_WIDTH: cfg_w = csr_data;
               REG_ROI_HEIGHT: cfg_h = csr_data;
               REG_LINE_WIDTH: cfg_lw = csr_data;
               REG_METRIC: cfg_metric = csr_data[1:0];
               default: ;
            endcase
         end
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            frame_stats_step(req_data, done, calc);
            if (done) pending_stats.push_back(in_flight.typed ? in_flight.res : calc);
         end
         if (rsp_valid && rsp_ready) begin
            frames_done++;
            if (pending_stats.size() == 0) begin
               $error("result transaction with no expectation pending");
               failed = 1'b1;
            end else begin
               got_exp = pending_stats.pop_front();
               if (rsp_data.metric_value !== got_exp.metric_value) begin
                  $error("metric_value expected %h actual %h",
                         got_exp.metric_value, rsp_data.metric_value);
                  failed = 1'b1;
               end
               if (rsp_data.pixel_count !== got_exp.pixel_count) begin
                  $error("pixel_count expected %0d actual %0d",
                         got_exp.pixel_count, rsp_data.pixel_count);
                  failed = 1'b1;
               end
               if (rsp_data.min_sample !== got_exp.min_sample) begin
                  $error("min_sample expected %h actual %h",
                         got_exp.min_sample, rsp_data.min_sample);
                  failed = 1'b1;
               end
               if (rsp_data.max_sample !== got_exp.max_sample) begin
                  $error("max_sample expected %h actual %h",
                         got_exp.max_sample, rsp_data.max_sample);
                  failed = 1'b1;
               end
               if (rsp_data.empty_region !== got_exp.empty_region) begin
                  $error("empty_region expected %b actual %b",
                         got_exp.empty_region, rsp_data.empty_region);
                  failed = 1'b1;
               end
               if (rsp_data.zero_mean !== got_exp.zero_mean) begin
                  $error("zero_mean expected %b actual %b",
                         got_exp.zero_mean, rsp_data.zero_mean);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // sample sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            in_flight = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_data <= in_flight.req;
            items_sent++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: a randomly chosen and changing stall pattern,
   // plus one long hold-off so the block backs up its input
   int  mode_left = 0;
   int  rx_mode = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         if (!hold_done && frames_done >= 30) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // watchdog on cycles with no transaction at all
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("roi_frame_statistics_core verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_all(input logic [12:0] lw, x, y, w, h, input logic [1:0] m);
      write_reg(REG_LINE_WIDTH, lw);
      write_reg(REG_ROI_X, x);
      write_reg(REG_ROI_Y, y);
      write_reg(REG_ROI_WIDTH, w);
      write_reg(REG_ROI_HEIGHT, h);
      write_reg(REG_METRIC, {11'd0, m});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // block is idle once all samples went in and all frames came out
   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_valid || pending_stats.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_sample(input logic [15:0] s, input bit last,
                               input bit typed, input rfs_rsp_type res);
      sample_item_type it;
      it.req.sample = s;
      it.req.last_in_frame = last;
      it.typed = typed;
      it.res = res;
      sample_queue.push_back(it);
   endtask

   function automatic logic [15:0] pick_sample(int style, logic [15:0] base);
      case (style)
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
         2: return base;
         default: return 16'($urandom_range(0, 15));
      endcase
   endfunction

   frame_row_type frame_rows[9];

   initial begin
      int            len;
      int            style;
      logic [15:0]   base;
      logic [12:0]   lw, x, y, w, h;
      frame_row_type row;

      // directed frames: extremes, every metric, empty and zero-mean regions
      frame_rows[0] = '{13'd1024, 13'd0, 13'd0, 13'd1024, 13'd1024, METRIC_SUM, 1,
                        64'hFFFF, 1'b1, '{64'hFFFF0000, 25'd1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0}};
      frame_rows[1] = '{13'd1024, 13'd0, 13'd0, 13'd1024, 13'd1024, METRIC_SUM, 1,
                        64'h0, 1'b1, '{64'd0, 25'd1, 16'd0, 16'd0, 1'b0, 1'b1}};
      frame_rows[2] = '{13'd1024, 13'd0, 13'd0, 13'd0, 13'd1024, METRIC_MEAN, 1,
                        64'h5, 1'b1, '{64'd0, 25'd0, 16'd0, 16'd0, 1'b1, 1'b0}};
      frame_rows[3] = '{13'd2, 13'd0, 13'd0, 13'd2, 13'd2, METRIC_MEAN, 4,
                        64'h0001_FFFF_8000_0003, 1'b0, '0};
      frame_rows[4] = '{13'd2, 13'd0, 13'd0, 13'd2, 13'd2, METRIC_STD, 4,
                        64'h0001_FFFF_8000_0003, 1'b0, '0};
      frame_rows[5] = '{13'd3, 13'd1, 13'd0, 13'd1, 13'd0, METRIC_CV, 4,
                        64'h1234_FFFF_0007_0000, 1'b1, '{64'd0, 25'd0, 16'd0, 16'd0, 1'b1, 1'b0}};
      frame_rows[6] = '{13'd2, 13'd0, 13'd0, 13'd2, 13'd2, METRIC_CV, 4,
                        64'h0, 1'b1, '{64'd0, 25'd4, 16'd0, 16'd0, 1'b0, 1'b1}};
      frame_rows[7] = '{13'd0, 13'd4095, 13'd4095, 13'd4096, 13'd4096, METRIC_STD, 2,
                        64'h0000_0000_AAAA_5555, 1'b1, '{64'd0, 25'd0, 16'd0, 16'd0, 1'b1, 1'b0}};
      frame_rows[8] = '{13'd8191, 13'd1, 13'd0, 13'd8191, 13'd8191, METRIC_CV, 3,
                        64'h0000_0010_0030_FFFF, 1'b0, '0};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (frame_rows[i]) begin
         row = frame_rows[i];
         write_all(row.lw, row.x, row.y, row.w, row.h, row.metric);
         for (int k = 0; k < row.cnt; k++)
            queue_sample(row.samples[16*k +: 16], k == row.cnt - 1, row.typed, row.res);
         wait_idle();
      end

      // random phases, mostly small frames with an occasional extreme setting
      while (items_sent < 1750) begin
         lw = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(4096, 8191)) :
              ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 12));
         x = ($urandom_range(0, 9) == 0) ? 13'd4095 : 13'($urandom_range(0, 4));
         y = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3));
         w = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 6));
         h = ($urandom_range(0, 9) == 0) ? 13'd4096 : 13'($urandom_range(0, 5));
         write_all(lw, x, y, w, h, 2'($urandom_range(0, 3)));
         // occasional write to an unused index
         if ($urandom_range(0, 7) == 0) begin
            write_reg(3'($urandom_range(6, 7)), 13'($urandom));
            @(negedge clock);
            csr_valid <= 1'b0;
         end
         repeat ($urandom_range(2, 5)) begin
            len = $urandom_range(1, 40);
            style = $urandom_range(0, 3);
            base = 16'($urandom);
            for (int k = 0; k < len; k++)
               queue_sample(pick_sample(style, base), k == len - 1, 1'b0, '0);
         end
         wait_idle();
      end

      if (!failed && pending_stats.size() == 0)
         $display("roi_frame_statistics_core verification clean");
      else begin
         if (pending_stats.size() != 0)
            $error("%0d expected results never arrived", pending_stats.size());
         $display("roi_frame_statistics_core verification failed");
      end
      $finish;
   end

endmodule
